// ----- hw/rtl/fbpa_pkg.sv -----
// Package for the fixed block pool allocator: operation codes, states, constants.
`default_nettype none
package fbpa_pkg;

    localparam int KIND_W   = 2;
    localparam int CIDX_W   = 4;
    localparam int SIDX_W   = 6;
    localparam int SPC_W    = 7;
    localparam int CNT_W    = 7;
    localparam int REL_W    = 5;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam logic [CNT_W-1:0] COUNT_SAT = 7'd127;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_SHRINK = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAIM_SCAN,
        ST_CLAIM_FILL,
        ST_ALLOC_RD,
        ST_ALLOC_WR,
        ST_FREE_CHK,
        ST_SHRINK,
        ST_DONE
    } state_t;

endpackage : fbpa_pkg
`default_nettype wire

// ----- hw/rtl/fixed_block_pool_allocator_unit.sv -----
// Top level of the fixed block pool allocator with its slot link memory.
//
//  channel | direction | handshake              | contents
//  s_axis  | in        | s_axis_tvalid/tready   | tdata: kind, chunk_index, slot_index
//  m_axis  | out       | m_axis_tvalid/tready   | tdata: status, given_chunk, given_slot,
//          |           |                        |        released_count
//  cfg     | in        | cfg_valid/cfg_ready    | slots_per_chunk
//
// A no-operation transaction goes straight to the done state, a free passes one check
// state, and an allocation from a usable chunk reads the slot link memory, then writes
// the chunk head back. Allocation with no usable chunk first scans for an unheld chunk,
// one chunk per cycle, and fills its slot links, one slot per cycle; with every chunk
// held it reports failure. Shrink releases chunks from the front of the usable list
// while the front chunk is fully free, then raises its result with the count released.
// On reset the state, held and full flags, counts, list ends and output valid clear and
// slots_per_chunk returns to 64; the slot link memory needs no clearing.
// A result waits in the output register; the next transaction is taken the cycle after
// it leaves, so no new transaction is taken while a result is waiting.
// The register write is taken only while idle with no result waiting.
`default_nettype none
module fixed_block_pool_allocator_unit #(
    parameter int CHUNK_COUNT = 16,
    parameter int SLOT_MAX    = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] kind, [5:2] chunk_index, [11:6] slot_index, rest zero
    input  wire logic [fbpa_pkg::IN_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // [0] status, [4:1] given_chunk, [10:5] given_slot, [15:11] released_count
    output logic [fbpa_pkg::OUT_W-1:0]    m_axis_tdata,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [fbpa_pkg::SPC_W-1:0] cfg_data
);
    import fbpa_pkg::*;

    localparam int CW  = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int CPW = $clog2(CHUNK_COUNT + 1);
    localparam int SW  = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
    localparam int SPW = $clog2(SLOT_MAX + 1);
    localparam int AW  = CW + SW;
    localparam logic [CPW-1:0] CNIL = CPW'(CHUNK_COUNT);
    localparam logic [SPW-1:0] SNIL = SPW'(SLOT_MAX);

    // Slot link memory: one write port, one registered read port.
    logic [SPW-1:0] link_mem [CHUNK_COUNT*SLOT_MAX];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [SPW-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= link_mem[mem_raddr];
    end

    // Per-chunk control state in flip-flops.
    logic [SPW-1:0] head_reg  [CHUNK_COUNT];
    logic [CNT_W-1:0] cnt_reg [CHUNK_COUNT];
    logic [CHUNK_COUNT-1:0] held_reg, full_reg;
    logic [CPW-1:0] prev_reg [CHUNK_COUNT];
    logic [CPW-1:0] next_reg [CHUNK_COUNT];
    logic [CPW-1:0] front_reg, back_reg;
    logic [SPC_W-1:0] spc_cfg_reg;

    state_t state_reg, state_next;
    logic [KIND_W-1:0] kind_reg;
    logic [CW-1:0] ci_reg, scan_reg;
    logic [SW-1:0] si_reg, h_reg;
    logic [SW-1:0] fill_reg;
    logic [REL_W-1:0] rel_reg;
    logic out_v_reg;
    logic [OUT_W-1:0] out_d_reg;

    // Effective slot count, clamped to 1..SLOT_MAX.
    logic [SPW:0] spc;
    always_comb
    begin
        if (spc_cfg_reg == '0)
            spc = (SPW+1)'(1);
        else if ({{(SPW+1 > SPC_W ? SPW+1-SPC_W : 0){1'b0}}, spc_cfg_reg} > (SPW+1)'(SLOT_MAX))
            spc = (SPW+1)'(SLOT_MAX);
        else
            spc = (SPW+1)'(spc_cfg_reg);
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_v_reg;
    assign cfg_ready     = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    logic [CW-1:0] back_c, front_c;
    assign back_c  = back_reg[CW-1:0];
    assign front_c = front_reg[CW-1:0];

    logic free_ok;
    logic [CNT_W-1:0] ci_cnt_inc;
    logic [CPW-1:0] ci_prev;
    assign ci_prev    = prev_reg[ci_reg];
    assign ci_cnt_inc = (cnt_reg[ci_reg] < COUNT_SAT) ? cnt_reg[ci_reg] + 1'b1
                                                      : cnt_reg[ci_reg];
    assign free_ok = ({{(32-CIDX_W){1'b0}}, s_axis_tdata[5:2]} < CHUNK_COUNT);

    logic free_valid;
    assign free_valid = held_reg[ci_reg]
                     && ((SPW+1)'(si_reg) < spc);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (kind_t'(s_axis_tdata[1:0]))
                        KIND_ALLOC:  state_next = (front_reg >= CNIL) ? ST_CLAIM_SCAN
                                                                      : ST_ALLOC_RD;
                        KIND_FREE:   state_next = ST_FREE_CHK;
                        KIND_SHRINK: state_next = ST_SHRINK;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLAIM_SCAN:
            begin
                if (!held_reg[scan_reg])
                    state_next = ST_CLAIM_FILL;
                else if (32'(scan_reg) == CHUNK_COUNT - 1)
                    state_next = ST_DONE;
            end
            ST_CLAIM_FILL:
            begin
                if ((SPW+1)'(fill_reg) + 1'b1 >= spc)
                    state_next = ST_ALLOC_RD;
            end
            ST_ALLOC_RD:  state_next = ST_ALLOC_WR;
            ST_ALLOC_WR:  state_next = ST_DONE;
            ST_FREE_CHK:  state_next = ST_DONE;
            ST_SHRINK:
            begin
                if (!(front_reg < CNIL
                      && {1'b0, cnt_reg[front_c]} >= (CNT_W+1)'(spc)))
                    state_next = ST_DONE;
            end
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {ci_reg, si_reg};
        mem_wdata = head_reg[ci_reg];
        mem_raddr = {back_c, h_reg};
        case (state_reg)
            ST_CLAIM_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = {scan_reg, fill_reg};
                mem_wdata = ((SPW+1)'(fill_reg) + 1'b1 < spc) ? SPW'(fill_reg) + 1'b1 : SNIL;
            end
            ST_FREE_CHK:
            begin
                mem_we = free_valid;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control and list state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            full_reg    <= '0;
            front_reg   <= CNIL;
            back_reg    <= CNIL;
            spc_cfg_reg <= SPC_W'(64);
            out_v_reg   <= 1'b0;
            for (int i = 0; i < CHUNK_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                spc_cfg_reg <= cfg_data;
            if (out_v_reg && m_axis_tready)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        // A free of a chunk outside the pool is carried as a no-operation.
                        kind_reg <= (kind_t'(s_axis_tdata[1:0]) == KIND_FREE && !free_ok)
                                    ? KIND_NOP : s_axis_tdata[1:0];
                        ci_reg   <= s_axis_tdata[CW+1:2];
                        si_reg   <= s_axis_tdata[SW+5:6];
                        scan_reg <= '0;
                        fill_reg <= '0;
                        rel_reg  <= '0;
                        out_d_reg <= '0;
                        if (front_reg < CNIL)
                            h_reg <= (head_reg[back_reg[CW-1:0]] >= SNIL) ? '0
                                     : head_reg[back_reg[CW-1:0]][SW-1:0];
                    end
                end
                ST_CLAIM_SCAN:
                begin
                    if (held_reg[scan_reg])
                    begin
                        if (32'(scan_reg) == CHUNK_COUNT - 1)
                            out_d_reg[0] <= 1'b1;
                        else
                            scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_CLAIM_FILL:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    if ((SPW+1)'(fill_reg) + 1'b1 >= spc)
                    begin
                        held_reg[scan_reg] <= 1'b1;
                        full_reg[scan_reg] <= 1'b0;
                        head_reg[scan_reg] <= '0;
                        cnt_reg[scan_reg]  <= CNT_W'(spc);
                        next_reg[scan_reg] <= front_reg;
                        prev_reg[scan_reg] <= CNIL;
                        if (front_reg >= CNIL)
                            back_reg <= CPW'(scan_reg);
                        else
                            prev_reg[front_c] <= CPW'(scan_reg);
                        front_reg <= CPW'(scan_reg);
                        h_reg <= '0;
                    end
                end
                ST_ALLOC_WR:
                begin
                    head_reg[back_c] <= mem_rdata;
                    out_d_reg[4:1]   <= 4'(back_c);
                    out_d_reg[10:5]  <= 6'(h_reg);
                    if (cnt_reg[back_c] <= CNT_W'(1))
                    begin
                        cnt_reg[back_c]  <= '0;
                        full_reg[back_c] <= 1'b1;
                        // Unlink the back chunk.
                        if (prev_reg[back_c] >= CNIL)
                            front_reg <= next_reg[back_c];
                        else
                            next_reg[prev_reg[back_c][CW-1:0]] <= next_reg[back_c];
                        back_reg <= prev_reg[back_c];
                    end
                    else
                        cnt_reg[back_c] <= cnt_reg[back_c] - 1'b1;
                end
                ST_FREE_CHK:
                begin
                    if (kind_reg == KIND_FREE && free_valid)
                    begin
                        head_reg[ci_reg] <= SPW'(si_reg);
                        cnt_reg[ci_reg]  <= ci_cnt_inc;
                        if (ci_cnt_inc == CNT_W'(1))
                        begin
                            if (full_reg[ci_reg])
                            begin
                                full_reg[ci_reg] <= 1'b0;
                                prev_reg[ci_reg] <= back_reg;
                                next_reg[ci_reg] <= CNIL;
                                if (back_reg >= CNIL)
                                    front_reg <= CPW'(ci_reg);
                                else
                                    next_reg[back_c] <= CPW'(ci_reg);
                                back_reg <= CPW'(ci_reg);
                            end
                            // A chunk already listed with a count of one is
                            // unlinked and pushed back: net effect is a move.
                            else if (back_reg != CPW'(ci_reg))
                            begin
                                if (ci_prev >= CNIL)
                                    front_reg <= next_reg[ci_reg];
                                else
                                    next_reg[ci_prev[CW-1:0]] <= next_reg[ci_reg];
                                prev_reg[next_reg[ci_reg][CW-1:0]] <= ci_prev;
                                prev_reg[ci_reg] <= back_reg;
                                next_reg[ci_reg] <= CNIL;
                                next_reg[back_c] <= CPW'(ci_reg);
                                back_reg <= CPW'(ci_reg);
                            end
                        end
                        else if ({1'b0, ci_cnt_inc} >= (CNT_W+1)'(spc)
                                 && ci_prev < CNIL
                                 && {1'b0, cnt_reg[ci_prev[CW-1:0]]} != (CNT_W+1)'(spc))
                        begin
                            // Move a fully free chunk to the front.
                            next_reg[ci_prev[CW-1:0]] <= next_reg[ci_reg];
                            if (next_reg[ci_reg] >= CNIL)
                                back_reg <= ci_prev;
                            else
                                prev_reg[next_reg[ci_reg][CW-1:0]] <= ci_prev;
                            prev_reg[ci_reg] <= CNIL;
                            next_reg[ci_reg] <= front_reg;
                            prev_reg[front_c] <= CPW'(ci_reg);
                            front_reg <= CPW'(ci_reg);
                        end
                    end
                end
                ST_SHRINK:
                begin
                    if (front_reg < CNIL
                        && {1'b0, cnt_reg[front_c]} >= (CNT_W+1)'(spc))
                    begin
                        held_reg[front_c] <= 1'b0;
                        full_reg[front_c] <= 1'b0;
                        cnt_reg[front_c]  <= '0;
                        rel_reg <= rel_reg + 1'b1;
                        front_reg <= next_reg[front_c];
                        if (next_reg[front_c] >= CNIL)
                            back_reg <= CNIL;
                        else
                            prev_reg[next_reg[front_c][CW-1:0]] <= CNIL;
                    end
                    else
                        out_d_reg[15:11] <= rel_reg;
                end
                ST_DONE:
                begin
                    out_v_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Assertions.
    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !m_axis_tready) |=> (out_v_reg && $stable(out_d_reg)))
        else $error("result dropped");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_v_reg)
        else $error("result not presented");
    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (front_reg >= CNIL) == (back_reg >= CNIL))
        else $error("list ends disagree");

endmodule : fixed_block_pool_allocator_unit
`default_nettype wire

// ----- tb/sv/tb_fixed_block_pool_allocator_unit.sv -----
// Self-checking testbench for the fixed block pool allocator unit.
`default_nettype none
module tb_fixed_block_pool_allocator_unit;
    import fbpa_pkg::*;

    localparam int NCHUNK = 16;
    localparam int NSLOT = 64;
    localparam int RANDOM_ITEMS = 1792;
    localparam int CYCLE_LIMIT = 1000000;

    // One expected result as it appears on the output stream.
    typedef struct packed {
        logic [REL_W-1:0]  released;
        logic [SIDX_W-1:0] slot;
        logic [CIDX_W-1:0] chunk;
        logic              status;
    } result_t;

    // One row of the directed table; has_fixed marks rows whose result is typed in.
    typedef struct {
        kind_t            kind;
        logic [3:0]       chunk;
        logic [5:0]       slot;
        bit               has_fixed;
        result_t          fixed;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SPC_W-1:0] cfg_data = '0;

    fixed_block_pool_allocator_unit #(.CHUNK_COUNT(NCHUNK), .SLOT_MAX(NSLOT)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the allocator state.
    int        link_mem [NCHUNK*NSLOT];
    int        head [NCHUNK];
    int        count [NCHUNK];
    bit        held [NCHUNK];
    bit        full [NCHUNK];
    int        prev_c [NCHUNK];
    int        next_c [NCHUNK];
    int        front_c;
    int        back_c;
    logic [SPC_W-1:0] spc_reg;

    // Blocks handed out and not yet freed, so the stimulus can free real blocks.
    int        live_blocks [$];

    result_t   pending_results [$];
    int        errors = 0;
    int        cycles = 0;
    bit        stim_done = 1'b0;

    function automatic int slots_in_use();
        int s;
        s = spc_reg;
        if (s < 1) s = 1;
        if (s > NSLOT) s = NSLOT;
        return s;
    endfunction

    function automatic void usable_remove(int c);
        if (prev_c[c] >= NCHUNK) front_c = next_c[c]; else next_c[prev_c[c]] = next_c[c];
        if (next_c[c] >= NCHUNK) back_c = prev_c[c]; else prev_c[next_c[c]] = prev_c[c];
    endfunction

    function automatic void usable_add_back(int c);
        prev_c[c] = back_c;
        next_c[c] = NCHUNK;
        if (back_c >= NCHUNK) front_c = c; else next_c[back_c] = c;
        back_c = c;
    endfunction

    function automatic void usable_add_front(int c);
        next_c[c] = front_c;
        prev_c[c] = NCHUNK;
        if (front_c >= NCHUNK) back_c = c; else prev_c[front_c] = c;
        front_c = c;
    endfunction

    function automatic void pool_reset();
        foreach (link_mem[i]) link_mem[i] = 0;
        for (int c = 0; c < NCHUNK; c++)
        begin
            head[c] = 0; count[c] = 0; held[c] = 0; full[c] = 0;
            prev_c[c] = 0; next_c[c] = 0;
        end
        front_c = NCHUNK;
        back_c = NCHUNK;
        spc_reg = 7'd64;
        live_blocks.delete();
    endfunction

    // Computes the result of one transaction and advances the shadow state.
    function automatic result_t pool_step(kind_t kind, int ci, int si);
        result_t r;
        int spc, c, h, p, n;
        bit found;
        r = '0;
        spc = slots_in_use();
        case (kind)
            KIND_ALLOC:
            begin
                if (front_c >= NCHUNK)
                begin
                    found = 0;
                    for (c = 0; c < NCHUNK; c++)
                        if (!held[c]) begin found = 1; break; end
                    if (!found)
                    begin
                        r.status = 1'b1;
                        return r;
                    end
                    for (int i = 0; i < spc; i++)
                        link_mem[c*NSLOT+i] = (i + 1 < spc) ? i + 1 : NSLOT;
                    held[c] = 1; full[c] = 0; head[c] = 0; count[c] = spc;
                    usable_add_front(c);
                end
                c = back_c;
                h = head[c];
                if (h >= NSLOT) h = 0;
                head[c] = link_mem[c*NSLOT+h];
                if (count[c] > 0) count[c]--;
                if (count[c] == 0)
                begin
                    usable_remove(c);
                    full[c] = 1;
                end
                r.chunk = c[3:0];
                r.slot = h[5:0];
                live_blocks.push_back(c*NSLOT + h);
            end
            KIND_FREE:
            begin
                if (!held[ci] || si >= spc) return r;
                link_mem[ci*NSLOT+si] = head[ci];
                head[ci] = si;
                if (count[ci] < COUNT_SAT) count[ci]++;
                if (count[ci] == 1)
                begin
                    if (full[ci]) full[ci] = 0; else usable_remove(ci);
                    usable_add_back(ci);
                    return r;
                end
                if (count[ci] < spc) return r;
                p = prev_c[ci];
                if (p >= NCHUNK) return r;
                if (count[p] == spc) return r;
                usable_remove(ci);
                usable_add_front(ci);
            end
            KIND_SHRINK:
            begin
                n = 0;
                while (front_c < NCHUNK && count[front_c] >= spc)
                begin
                    c = front_c;
                    usable_remove(c);
                    held[c] = 0; full[c] = 0; count[c] = 0;
                    // Blocks of a released chunk are no longer live.
                    for (int k = live_blocks.size() - 1; k >= 0; k--)
                        if (live_blocks[k] / NSLOT == c) live_blocks.delete(k);
                    n++;
                end
                r.released = n[4:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // Sends one transaction; the expected result is queued at acceptance.
    task automatic send_item(kind_t kind, int ci, int si, bit has_fixed, result_t fixed);
        result_t r;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            idle_cycles(gap);
        end
        s_axis_tdata <= {4'b0, si[5:0], ci[3:0], kind};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        r = pool_step(kind, ci, si);
        if (has_fixed && r != fixed)
        begin
            // A fixed row that disagrees with the predictor points at the table itself.
            errors++;
            if (errors <= 10)
                $display("table row disagrees with predictor: %h vs %h", fixed, r);
        end
        pending_results.push_back(has_fixed ? fixed : r);
    endtask

    // Register write while the block is idle.
    task automatic write_spc(int value);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        idle_cycles(100);
        cfg_data <= SPC_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        spc_reg = SPC_W'(value);
    endtask

    // Random transaction: mostly allocations and frees of live blocks.
    task automatic random_item();
        int pick, ci, si, idx;
        kind_t kind;
        pick = $urandom_range(0, 99);
        ci = $urandom_range(0, 15);
        si = $urandom_range(0, 63);
        if (pick < 45) kind = KIND_ALLOC;
        else if (pick < 88)
        begin
            kind = KIND_FREE;
            if (live_blocks.size() > 0 && $urandom_range(0, 9) != 0)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                ci = live_blocks[idx] / NSLOT;
                si = live_blocks[idx] % NSLOT;
                live_blocks.delete(idx);
            end
        end
        else if (pick < 97) kind = KIND_SHRINK;
        else kind = KIND_NOP;
        send_item(kind, ci, si, 1'b0, '0);
    endtask

    // Output side: random stalls, field-by-field comparison with the oldest expectation.
    initial
    begin : result_check
        result_t got, want;
        int stall;
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                idle_cycles(stall);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.chunk !== want.chunk ||
                    got.slot !== want.slot || got.released !== want.released)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected st=%0d c=%0d s=%0d rel=%0d, got st=%0d c=%0d s=%0d rel=%0d",
                            want.status, want.chunk, want.slot, want.released,
                            got.status, got.chunk, got.slot, got.released);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        row_t rows [$];
        result_t ok;
        row_t row;
        int settings [7];
        ok = '0;
        settings = '{64, 1, 127, 3, 17, 5, 64};
        pool_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under slots_per_chunk of 2: the first allocations fill chunk 0.
        write_spc(2);
        rows.push_back(row_t'{KIND_NOP,    4'd0,  6'd0,  1, ok});
        rows.push_back(row_t'{KIND_SHRINK, 4'd0,  6'd0,  1, ok});
        rows.push_back(row_t'{KIND_FREE,   4'd3,  6'd0,  1, ok});           // unheld chunk
        rows.push_back(row_t'{KIND_ALLOC,  4'd0,  6'd0,  1, '{0, 0, 0, 0}});
        rows.push_back(row_t'{KIND_ALLOC,  4'd0,  6'd0,  1, '{0, 1, 0, 0}});
        rows.push_back(row_t'{KIND_ALLOC,  4'd15, 6'd63, 1, '{0, 0, 1, 0}});
        rows.push_back(row_t'{KIND_FREE,   4'd0,  6'd63, 1, ok});           // slot out of range
        rows.push_back(row_t'{KIND_FREE,   4'd0,  6'd1,  1, ok});
        rows.push_back(row_t'{KIND_FREE,   4'd0,  6'd0,  0, ok});
        rows.push_back(row_t'{KIND_SHRINK, 4'd0,  6'd0,  0, ok});
        rows.push_back(row_t'{KIND_FREE,   4'd0,  6'd0,  0, ok});           // unallocated block
        rows.push_back(row_t'{KIND_FREE,   4'd0,  6'd1,  0, ok});
        rows.push_back(row_t'{KIND_ALLOC,  4'd0,  6'd0,  0, ok});
        rows.push_back(row_t'{KIND_ALLOC,  4'd0,  6'd0,  0, ok});
        rows.push_back(row_t'{KIND_FREE,   4'd1,  6'd1,  0, ok});
        rows.push_back(row_t'{KIND_SHRINK, 4'd0,  6'd0,  0, ok});
        foreach (rows[i])
        begin
            row = rows[i];
            send_item(row.kind, row.chunk, row.slot, row.has_fixed, row.fixed);
        end

        // Pool exhaustion with one slot per chunk: sixteen grants, then failures.
        write_spc(0);
        for (int i = 0; i < 17; i++) send_item(KIND_ALLOC, 0, 0, 0, '0);
        send_item(KIND_ALLOC, 15, 63, 1, result_t'{0, 0, 0, 1});
        for (int c = 0; c < NCHUNK; c++) send_item(KIND_FREE, c, 0, 0, '0);
        send_item(KIND_SHRINK, 0, 0, 1, result_t'{16, 0, 0, 0});

        // Random phases across several register settings, extremes included.
        foreach (settings[k])
        begin
            write_spc(settings[k]);
            for (int i = 0; i < RANDOM_ITEMS / 7; i++) random_item();
            // Release the fully free chunks at the front of the usable list at the end of the phase.
            send_item(KIND_SHRINK, 0, 0, 0, '0);
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        idle_cycles(200);
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

// ----- fixed_block_pool_allocator_unit.f -----
hw/rtl/fbpa_pkg.sv
hw/rtl/fixed_block_pool_allocator_unit.sv
tb/sv/tb_fixed_block_pool_allocator_unit.sv
